[design/pump_redundancy_transition_sequencer_unit_assert.svh]
// Assertion helpers for the sequencer RTL, included by prts_step.
`ifndef PUMP_REDUNDANCY_TRANSITION_SEQUENCER_UNIT_ASSERT_SVH
`define PUMP_REDUNDANCY_TRANSITION_SEQUENCER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define PRTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define PRTS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[design/prts_pkg.sv]
`default_nettype none

package prts_pkg;

	localparam int REQ_W   = 8;
	localparam int MODE_W  = 2;
	localparam int DUTY_W  = 7;
	localparam int CNT_W   = 8;
	localparam int NUM_PUMPS = 3;

	localparam int FIRST_STAGE_TICKS_DEF  = 3;
	localparam int SECOND_STAGE_TICKS_DEF = 3;
	localparam int THIRD_STAGE_TICKS_DEF  = 3;

	localparam logic [REQ_W-1:0]  DUTY_LIMIT          = 8'd100;
	localparam logic [DUTY_W-1:0] STAGE_ALL_DUTY      = 7'd55;
	localparam logic [DUTY_W-1:0] STAGE_IDLE_LOW_DUTY = 7'd20;
	localparam logic [DUTY_W-1:0] FULL_DUTY           = 7'd100;
	localparam logic [DUTY_W-1:0] OFF_DUTY            = 7'd0;

	// redundancy mode codes
	localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_P3_IDLE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_P2_IDLE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_P1_IDLE  = 2'd3;

	// idle pump encoding: 0 none, else pump number
	localparam logic [1:0] IDLE_NONE = 2'd0;
	localparam logic [1:0] IDLE_P1   = 2'd1;
	localparam logic [1:0] IDLE_P2   = 2'd2;
	localparam logic [1:0] IDLE_P3   = 2'd3;

	typedef logic [NUM_PUMPS-1:0][DUTY_W-1:0] drive_set_t;

	typedef struct packed {
		logic [REQ_W-1:0]  pump1_request;
		logic [REQ_W-1:0]  pump2_request;
		logic [REQ_W-1:0]  pump3_request;
		logic [MODE_W-1:0] redundancy_mode;
	} tick_t;

	typedef struct packed {
		drive_set_t drive;
		logic       rejected;
		logic       handover_active;
	} result_t;

	function automatic logic [1:0] idle_from_mode(input logic [MODE_W-1:0] mode);
		logic [1:0] idle;
		case (mode)
			MODE_P3_IDLE: idle = IDLE_P3;
			MODE_P2_IDLE: idle = IDLE_P2;
			MODE_P1_IDLE: idle = IDLE_P1;
			default:      idle = IDLE_NONE;
		endcase
		return idle;
	endfunction

	function automatic drive_set_t drive_split(input logic [1:0] idle,
			input logic [DUTY_W-1:0] idle_duty, input logic [DUTY_W-1:0] other_duty);
		drive_set_t d;
		for (int k = 0; k < NUM_PUMPS; k++) begin
			d[k] = (idle == 2'(k + 1)) ? idle_duty : other_duty;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[design/prts_if.sv]
`default_nettype none

// Tick channel: requested duties and redundancy mode.
interface prts_tick_if;
	logic       valid;
	logic       ready;
	logic [7:0] pump1_request;
	logic [7:0] pump2_request;
	logic [7:0] pump3_request;
	logic [1:0] redundancy_mode;

	modport source (output valid, pump1_request, pump2_request, pump3_request,
		redundancy_mode, input ready);
	modport sink (input valid, pump1_request, pump2_request, pump3_request,
		redundancy_mode, output ready);
endinterface

// Result channel: driven duties and status.
interface prts_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] pump1_drive;
	logic [6:0] pump2_drive;
	logic [6:0] pump3_drive;
	logic       rejected;
	logic       handover_active;

	modport source (output valid, pump1_drive, pump2_drive, pump3_drive, rejected,
		handover_active, input ready);
	modport sink (input valid, pump1_drive, pump2_drive, pump3_drive, rejected,
		handover_active, output ready);
endinterface

`default_nettype wire

[design/pump_redundancy_transition_sequencer_unit.sv]
// Pump redundancy handover sequencer.
//
// tick   : sink channel, one control tick per word: three requested duties
//          (percent) and the redundancy mode naming the idle pump.
// result : source channel, one word per tick: three driven duties, a reject
//          flag (a request above 100 leaves drives and state as they were)
//          and the handover flag.
// A word moves when valid and ready are both high at a rising clk edge.
// The tick is registered, then the sequencer update runs between that
// register and the result register. Throughput is one tick per cycle
// unless result.ready stalls; the only loop is the state update in prts_step.
// A new tick is taken while a result waits, as long as the input register
// can move on; when result.ready is low with both registers full, tick.ready
// drops and everything holds.
// arst_n clears the sequencer: no idle pump recorded, no handover, stage
// counts at their start values, last driven duties at 0, both channels empty.
`default_nettype none

module pump_redundancy_transition_sequencer_unit #(
	parameter int FIRST_STAGE_TICKS  = prts_pkg::FIRST_STAGE_TICKS_DEF,
	parameter int SECOND_STAGE_TICKS = prts_pkg::SECOND_STAGE_TICKS_DEF,
	parameter int THIRD_STAGE_TICKS  = prts_pkg::THIRD_STAGE_TICKS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	prts_tick_if.sink     tick,
	prts_result_if.source result
);
	import prts_pkg::*;

	logic    valid_s1;
	tick_t   tick_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.pump1_request   <= tick.pump1_request;
			tick_s1.pump2_request   <= tick.pump2_request;
			tick_s1.pump3_request   <= tick.pump3_request;
			tick_s1.redundancy_mode <= tick.redundancy_mode;
		end
	end

	prts_step #(
		.FIRST_STAGE_TICKS  (FIRST_STAGE_TICKS),
		.SECOND_STAGE_TICKS (SECOND_STAGE_TICKS),
		.THIRD_STAGE_TICKS  (THIRD_STAGE_TICKS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.tick   (tick_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.pump1_drive     = res_q.drive[0];
	assign result.pump2_drive     = res_q.drive[1];
	assign result.pump3_drive     = res_q.drive[2];
	assign result.rejected        = res_q.rejected;
	assign result.handover_active = res_q.handover_active;

endmodule

`default_nettype wire

[design/prts_step.sv]
`default_nettype none
`include "pump_redundancy_transition_sequencer_unit_assert.svh"

// Sequencer state and the per-tick update. State moves only on fire.
module prts_step #(
	parameter int FIRST_STAGE_TICKS  = prts_pkg::FIRST_STAGE_TICKS_DEF,
	parameter int SECOND_STAGE_TICKS = prts_pkg::SECOND_STAGE_TICKS_DEF,
	parameter int THIRD_STAGE_TICKS  = prts_pkg::THIRD_STAGE_TICKS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire prts_pkg::tick_t  tick,
	output prts_pkg::result_t     res
);
	import prts_pkg::*;

	localparam logic [1:0] PH_RAMP   = 2'd0;
	localparam logic [1:0] PH_BOOST  = 2'd1;
	localparam logic [1:0] PH_SETTLE = 2'd2;
	localparam logic [1:0] PH_FINISH = 2'd3;

	localparam logic [CNT_W-1:0] RAMP_INIT   = CNT_W'(FIRST_STAGE_TICKS);
	localparam logic [CNT_W-1:0] BOOST_INIT  = CNT_W'(SECOND_STAGE_TICKS);
	localparam logic [CNT_W-1:0] SETTLE_INIT = CNT_W'(THIRD_STAGE_TICKS);

	logic [1:0]       phase_q, phase_n;
	logic [1:0]       idle_now_q, idle_now_n;
	logic [1:0]       idle_before_q, idle_before_n;
	logic [CNT_W-1:0] ramp_q, ramp_n;
	logic [CNT_W-1:0] boost_q, boost_n;
	logic [CNT_W-1:0] settle_q, settle_n;
	logic             in_hand_q, in_hand_n;
	drive_set_t       held_q, held_n;

	logic             reject;
	logic [1:0]       chosen;
	logic [1:0]       idle_sel;
	logic             staged;
	logic [CNT_W-1:0] cnt_dec;
	drive_set_t       normal;

	always_comb begin
		phase_n       = phase_q;
		idle_now_n    = idle_now_q;
		idle_before_n = idle_before_q;
		ramp_n        = ramp_q;
		boost_n       = boost_q;
		settle_n      = settle_q;
		in_hand_n     = in_hand_q;
		held_n        = held_q;
		staged        = 1'b0;
		cnt_dec       = '0;

		reject = (tick.pump1_request > DUTY_LIMIT) ||
			(tick.pump2_request > DUTY_LIMIT) ||
			(tick.pump3_request > DUTY_LIMIT);
		chosen   = idle_from_mode(tick.redundancy_mode);
		idle_sel = in_hand_q ? idle_now_q : chosen;

		// requests are at most 100 here, so the low seven bits carry them
		normal[0] = (chosen == IDLE_P1) ? OFF_DUTY : tick.pump1_request[DUTY_W-1:0];
		normal[1] = (chosen == IDLE_P2) ? OFF_DUTY : tick.pump2_request[DUTY_W-1:0];
		normal[2] = (chosen == IDLE_P3) ? OFF_DUTY : tick.pump3_request[DUTY_W-1:0];

		if (!reject) begin
			idle_now_n = idle_sel;
			if (idle_sel != IDLE_NONE && idle_before_q != idle_sel) begin
				case (phase_q)
					PH_RAMP: begin
						if (idle_before_q != IDLE_NONE) begin
							in_hand_n = 1'b1;
							held_n    = drive_split(IDLE_NONE, STAGE_ALL_DUTY, STAGE_ALL_DUTY);
							cnt_dec   = ramp_q - 1'b1;
							if (cnt_dec == '0) begin
								phase_n = PH_BOOST;
								ramp_n  = RAMP_INIT;
							end else begin
								ramp_n = cnt_dec;
							end
							staged = 1'b1;
						end else begin
							// first idle choice: record it, no handover
							idle_before_n = idle_sel;
						end
					end
					PH_BOOST: begin
						held_n  = drive_split(idle_sel, STAGE_IDLE_LOW_DUTY, FULL_DUTY);
						cnt_dec = boost_q - 1'b1;
						if (cnt_dec == '0) begin
							phase_n = PH_SETTLE;
							boost_n = BOOST_INIT;
						end else begin
							boost_n = cnt_dec;
						end
						staged = 1'b1;
					end
					PH_SETTLE: begin
						held_n  = drive_split(idle_sel, OFF_DUTY, FULL_DUTY);
						cnt_dec = settle_q - 1'b1;
						if (cnt_dec == '0) begin
							phase_n  = PH_FINISH;
							settle_n = SETTLE_INIT;
						end else begin
							settle_n = cnt_dec;
						end
						staged = 1'b1;
					end
					default: begin
						// finishing: record the new idle pump, flag drops next tick
						idle_before_n = idle_sel;
					end
				endcase
			end else begin
				in_hand_n = 1'b0;
				phase_n   = PH_RAMP;
				if (idle_sel == IDLE_NONE) begin
					idle_before_n = IDLE_NONE;
				end
			end
			if (!staged) begin
				held_n = normal;
			end
		end

		res.drive           = held_n;
		res.rejected        = reject;
		res.handover_active = in_hand_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_RAMP;
			idle_now_q    <= IDLE_NONE;
			idle_before_q <= IDLE_NONE;
			ramp_q        <= RAMP_INIT;
			boost_q       <= BOOST_INIT;
			settle_q      <= SETTLE_INIT;
			in_hand_q     <= 1'b0;
			held_q        <= '0;
		end else if (fire) begin
			phase_q       <= phase_n;
			idle_now_q    <= idle_now_n;
			idle_before_q <= idle_before_n;
			ramp_q        <= ramp_n;
			boost_q       <= boost_n;
			settle_q      <= settle_n;
			in_hand_q     <= in_hand_n;
			held_q        <= held_n;
		end
	end

	// a rejected word leaves the sequence untouched
	`PRTS_ASSERT(a_reject_holds, clk, arst_n, fire && reject |=> $stable(phase_q) && $stable(idle_before_q) && $stable(in_hand_q) && $stable(held_q), "rejected word changed state")

	// a staged phase is only ever reached inside a handover
	`PRTS_ASSERT_ALWAYS(a_phase_in_handover, clk, (phase_q != PH_RAMP) |-> in_hand_q, "handover phase without handover flag")

	// a handover always has a previous idle pump to move away from
	`PRTS_ASSERT(a_handover_has_prev, clk, arst_n, in_hand_q |-> (idle_before_q != IDLE_NONE), "handover with no previous idle pump")

	// the frozen idle pump does not move while the handover runs
	`PRTS_ASSERT(a_idle_frozen, clk, arst_n, fire && in_hand_q |=> $stable(idle_now_q), "idle pump moved during handover")

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import prts_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_TICKS  = 600;
	localparam int CALM_TICKS    = 60;

	typedef enum logic [1:0] {
		STAGE_RAMP   = 2'd0,
		STAGE_BOOST  = 2'd1,
		STAGE_SETTLE = 2'd2,
		STAGE_FINISH = 2'd3
	} stage_e;

	class drive_scoreboard;
		result_t    expected_drives[$];
		int         errors;
		stage_e     stage;
		logic [1:0] idle_now;
		logic [1:0] idle_prev;
		logic [7:0] ramp_left;
		logic [7:0] boost_left;
		logic [7:0] settle_left;
		logic       in_handover;
		drive_set_t last_drive;

		function new();
			errors      = 0;
			stage       = STAGE_RAMP;
			idle_now    = IDLE_NONE;
			idle_prev   = IDLE_NONE;
			ramp_left   = 8'(FIRST_STAGE_TICKS_DEF);
			boost_left  = 8'(SECOND_STAGE_TICKS_DEF);
			settle_left = 8'(THIRD_STAGE_TICKS_DEF);
			in_handover = 1'b0;
			last_drive  = '0;
		endfunction

		function drive_set_t duties_around_idle(logic [1:0] idle, logic [DUTY_W-1:0] idle_duty,
				logic [DUTY_W-1:0] rest_duty);
			drive_set_t d;
			for (int k = 0; k < NUM_PUMPS; k++)
				d[k] = (idle == 2'(k + 1)) ? idle_duty : rest_duty;
			return d;
		endfunction

		function result_t advance_sequencer(tick_t t);
			logic [7:0] rq[NUM_PUMPS];
			logic [1:0] pick;
			bit         staged;
			result_t    r;
			rq[0] = t.pump1_request;
			rq[1] = t.pump2_request;
			rq[2] = t.pump3_request;
			r.rejected = 1'b0;
			if (rq[0] > DUTY_LIMIT || rq[1] > DUTY_LIMIT ||
					rq[2] > DUTY_LIMIT) begin
				r.drive           = last_drive;
				r.rejected        = 1'b1;
				r.handover_active = in_handover;
				return r;
			end
			case (t.redundancy_mode)
				MODE_P3_IDLE: pick = IDLE_P3;
				MODE_P2_IDLE: pick = IDLE_P2;
				MODE_P1_IDLE: pick = IDLE_P1;
				default:      pick = IDLE_NONE;
			endcase
			// idle pump stays frozen for the whole handover
			if (!in_handover)
				idle_now = pick;
			staged = 1'b0;
			if (idle_now != IDLE_NONE && idle_prev != idle_now) begin
				case (stage)
					STAGE_RAMP: begin
						if (idle_prev != IDLE_NONE) begin
							in_handover = 1'b1;
							last_drive  = {NUM_PUMPS{STAGE_ALL_DUTY}};
							ramp_left   = ramp_left - 8'd1;
							if (ramp_left == 8'd0) begin
								stage     = STAGE_BOOST;
								ramp_left = 8'(FIRST_STAGE_TICKS_DEF);
							end
							staged = 1'b1;
						end else begin
							idle_prev = idle_now;
						end
					end
					STAGE_BOOST: begin
						last_drive = duties_around_idle(idle_now, STAGE_IDLE_LOW_DUTY, FULL_DUTY);
						boost_left = boost_left - 8'd1;
						if (boost_left == 8'd0) begin
							stage      = STAGE_SETTLE;
							boost_left = 8'(SECOND_STAGE_TICKS_DEF);
						end
						staged = 1'b1;
					end
					STAGE_SETTLE: begin
						last_drive  = duties_around_idle(idle_now, OFF_DUTY, FULL_DUTY);
						settle_left = settle_left - 8'd1;
						if (settle_left == 8'd0) begin
							stage       = STAGE_FINISH;
							settle_left = 8'(THIRD_STAGE_TICKS_DEF);
						end
						staged = 1'b1;
					end
					default: idle_prev = idle_now;
				endcase
			end else begin
				in_handover = 1'b0;
				stage       = STAGE_RAMP;
				if (idle_now == IDLE_NONE)
					idle_prev = IDLE_NONE;
			end
			// normal drives follow this word's mode, not the frozen pump
			if (!staged) begin
				for (int k = 0; k < NUM_PUMPS; k++)
					last_drive[k] = (pick == 2'(k + 1)) ? OFF_DUTY : rq[k][DUTY_W-1:0];
			end
			r.drive           = last_drive;
			r.handover_active = in_handover;
			return r;
		endfunction

		function void note_tick(tick_t t);
			expected_drives.push_back(advance_sequencer(t));
		endfunction

		function void report(string what, int want, int got);
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (expected_drives.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none actual %h", $time, got);
				return;
			end
			want = expected_drives.pop_front();
			if (got.drive[0] !== want.drive[0])
				report("pump1_drive", want.drive[0], got.drive[0]);
			if (got.drive[1] !== want.drive[1])
				report("pump2_drive", want.drive[1], got.drive[1]);
			if (got.drive[2] !== want.drive[2])
				report("pump3_drive", want.drive[2], got.drive[2]);
			if (got.rejected !== want.rejected)
				report("rejected", want.rejected, got.rejected);
			if (got.handover_active !== want.handover_active)
				report("handover_active", want.handover_active, got.handover_active);
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	prts_tick_if   tick_ch();
	prts_result_if res_ch();

	pump_redundancy_transition_sequencer_unit #(
		.FIRST_STAGE_TICKS (FIRST_STAGE_TICKS_DEF),
		.SECOND_STAGE_TICKS(SECOND_STAGE_TICKS_DEF),
		.THIRD_STAGE_TICKS (THIRD_STAGE_TICKS_DEF)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.result(res_ch)
	);

	always #6 clk = ~clk;

	drive_scoreboard sb = new();

	bit quiet = 1'b0;
	int gap_pct = 0;
	int stall_left = 0;
	int stall_pct = 0;
	int stall_seg = 0;
	int idle_cycles = 0;
	tick_t plan[$];

	// result side back-pressure in bursts; long segments with none at all
	always @(posedge clk) begin
		logic rdy;
		if (stall_seg == 0) begin
			stall_seg = $urandom_range(20, 80);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
		end
		stall_seg--;
		if (quiet)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(1, 100) <= stall_pct)
			stall_left = $urandom_range(1, 14);
		if (stall_left > 0) begin
			rdy = 1'b0;
			stall_left--;
		end else begin
			rdy = 1'b1;
		end
		res_ch.ready <= rdy;
	end

	// Sampled at the falling edge: these values hold through the next rising edge,
	// where the word actually moves.
	always @(negedge clk) begin
		tick_t   t;
		result_t r;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (tick_ch.valid && tick_ch.ready) begin
				t.pump1_request   = tick_ch.pump1_request;
				t.pump2_request   = tick_ch.pump2_request;
				t.pump3_request   = tick_ch.pump3_request;
				t.redundancy_mode = tick_ch.redundancy_mode;
				sb.note_tick(t);
				moved = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				r.drive[0]        = res_ch.pump1_drive;
				r.drive[1]        = res_ch.pump2_drive;
				r.drive[2]        = res_ch.pump3_drive;
				r.rejected        = res_ch.rejected;
				r.handover_active = res_ch.handover_active;
				sb.check_word(r);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_tick(input tick_t t);
		int  gap;
		bit  took;
		gap = 0;
		if (!quiet && $urandom_range(1, 100) <= gap_pct)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid           <= 1'b1;
		tick_ch.pump1_request   <= t.pump1_request;
		tick_ch.pump2_request   <= t.pump2_request;
		tick_ch.pump3_request   <= t.pump3_request;
		tick_ch.redundancy_mode <= t.redundancy_mode;
		forever begin
			@(negedge clk);
			took = tick_ch.ready;
			@(posedge clk);
			if (took)
				break;
		end
	endtask

	function automatic void add_tick(int p1, int p2, int p3, logic [MODE_W-1:0] m);
		tick_t t;
		t.pump1_request   = 8'(p1);
		t.pump2_request   = 8'(p2);
		t.pump3_request   = 8'(p3);
		t.redundancy_mode = m;
		plan.push_back(t);
	endfunction

	function automatic logic [REQ_W-1:0] pick_duty();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return DUTY_LIMIT;
			default: return REQ_W'($urandom_range(0, DUTY_LIMIT));
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		if ($urandom_range(0, 99) < 15)
			return MODE_NONE;
		case ($urandom_range(0, 2))
			0:       return MODE_P1_IDLE;
			1:       return MODE_P2_IDLE;
			default: return MODE_P3_IDLE;
		endcase
	endfunction

	function automatic tick_t random_tick(logic [MODE_W-1:0] m, bit bad);
		tick_t t;
		t.pump1_request   = pick_duty();
		t.pump2_request   = pick_duty();
		t.pump3_request   = pick_duty();
		t.redundancy_mode = m;
		if (bad) begin
			case ($urandom_range(0, 2))
				0:       t.pump1_request = REQ_W'($urandom_range(DUTY_LIMIT + 1, 255));
				1:       t.pump2_request = REQ_W'($urandom_range(DUTY_LIMIT + 1, 255));
				default: t.pump3_request = REQ_W'($urandom_range(DUTY_LIMIT + 1, 255));
			endcase
		end
		return t;
	endfunction

	initial begin
		int               n;
		int               len;
		logic [MODE_W-1:0] run_mode;
		logic [MODE_W-1:0] m;
		tick_ch.valid           = 1'b0;
		tick_ch.pump1_request   = '0;
		tick_ch.pump2_request   = '0;
		tick_ch.pump3_request   = '0;
		tick_ch.redundancy_mode = MODE_NONE;
		res_ch.ready            = 1'b0;
		arst_n                  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reject from reset, first pick, full handover with a reject and
		// mode changes while frozen, finishing word, leaving redundancy
		add_tick(101, 0, 0, MODE_NONE);
		add_tick(255, 255, 255, MODE_P1_IDLE);
		add_tick(0, 100, 50, MODE_NONE);
		add_tick(100, 100, 100, MODE_P3_IDLE);
		add_tick(7, 8, 9, MODE_P3_IDLE);
		add_tick(10, 20, 30, MODE_P2_IDLE);
		add_tick(10, 20, 30, MODE_P2_IDLE);
		add_tick(0, 0, 200, MODE_P2_IDLE);
		add_tick(10, 20, 30, MODE_P2_IDLE);
		add_tick(1, 2, 3, MODE_P1_IDLE);
		add_tick(1, 2, 3, MODE_P1_IDLE);
		add_tick(1, 2, 3, MODE_NONE);
		add_tick(4, 5, 6, MODE_NONE);
		add_tick(4, 5, 6, MODE_P3_IDLE);
		add_tick(4, 5, 6, MODE_P1_IDLE);
		add_tick(40, 50, 60, MODE_P3_IDLE);
		add_tick(40, 50, 60, MODE_P2_IDLE);
		add_tick(70, 80, 90, MODE_NONE);
		add_tick(100, 0, 100, MODE_P1_IDLE);
		add_tick(100, 0, 100, MODE_P3_IDLE);
		add_tick(100, 0, 100, MODE_NONE);
		add_tick(128, 0, 0, MODE_P2_IDLE);
		add_tick(0, 127, 0, MODE_P2_IDLE);
		gap_pct = 20;
		foreach (plan[i])
			send_tick(plan[i]);

		// random: runs of a mostly steady mode, of random length, with occasional rejects
		n = 0;
		while (n < RANDOM_TICKS) begin
			gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			run_mode = pick_mode();
			len      = $urandom_range(1, 14);
			for (int j = 0; j < len && n < RANDOM_TICKS; j++) begin
				quiet = (n >= RANDOM_TICKS - CALM_TICKS);
				m = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(0, 3)) : run_mode;
				send_tick(random_tick(m, $urandom_range(0, 9) == 0));
				n++;
				if (n == RANDOM_TICKS / 2) begin
					// hold off until the pipe has drained
					tick_ch.valid <= 1'b0;
					do @(posedge clk); while (sb.pending() != 0);
				end
			end
		end
		tick_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[pump_redundancy_transition_sequencer_unit.f]
+incdir+design
design/prts_pkg.sv
design/prts_if.sv
design/prts_step.sv
design/pump_redundancy_transition_sequencer_unit.sv
verif/tb_top.sv
